FILE: rtl/sorted_keyed_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted keyed table
// Concurrent assertion wrappers used by the controller module.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEYED_TABLE_CORE_ASSERT_SVH
`define SORTED_KEYED_TABLE_CORE_ASSERT_SVH

// check under reset gating
`define SKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define SKT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted keyed table package
// Sizes, codes and command/status types shared by the table modules.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [2:0] FUNC_INSERT = 3'd0;
  localparam logic [2:0] FUNC_SEARCH = 3'd1;
  localparam logic [2:0] FUNC_UPDATE = 3'd2;
  localparam logic [2:0] FUNC_ERASE  = 3'd3;
  localparam logic [2:0] FUNC_DUMP   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EXISTS   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    WR_RDATA,
    WR_NEW,
    WR_SUM
  } wr_sel_e;

  typedef enum logic [2:0] {
    OUT_RDATA,
    OUT_NEW,
    OUT_SUM,
    OUT_MISS,
    OUT_EMPTY
  } out_src_e;

  typedef struct packed {
    logic [30:0]        key;
    logic signed [31:0] qty;
    logic [15:0]        hnd;
  } entry_t;

  typedef struct packed {
    logic          in_ready;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    wr_sel_e       wr_sel;
    logic          out_load;
    out_src_e      out_src;
    status_e       out_status;
    logic          out_last;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] in_func;
    logic [2:0] func;
    logic       rkey_ge;
    logic       rkey_eq;
    logic       out_free;
  } sts_t;

endpackage

FILE: rtl/skt_stream_if.sv
// ----------------------------------------------------------------------------
// Sorted keyed table stream interfaces
// Valid/ready channels for operation requests and result items.
// ----------------------------------------------------------------------------
interface skt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [30:0]        part_key;
  logic signed [31:0] amount;
  logic [15:0]        name_handle;

  modport source (output valid, func, part_key, amount, name_handle, input ready);
  modport sink   (input valid, func, part_key, amount, name_handle, output ready);
endinterface

interface skt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [30:0]        found_key;
  logic signed [31:0] quantity;
  logic [15:0]        handle_out;
  logic               last;

  modport source (output valid, status, found_key, quantity, handle_out, last, input ready);
  modport sink   (input valid, status, found_key, quantity, handle_out, last, output ready);
endinterface

FILE: rtl/skt_dp.sv
// ----------------------------------------------------------------------------
// Sorted keyed table datapath
// Entry memory, request operands, saturating adder and result register.
// ----------------------------------------------------------------------------
module skt_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  skt_in_if.sink        in_i,
  skt_out_if.source     out_o,
  input  skt_pkg::cmd_t cmd_i,
  output skt_pkg::sts_t sts_o
);
  import skt_pkg::*;

  entry_t             mem_q [DEPTH];
  entry_t             rdata_q;
  entry_t             wdata;
  logic [2:0]         func_q;
  logic [30:0]        key_q;
  logic signed [31:0] amt_q;
  logic [15:0]        hnd_q;
  logic signed [32:0] sum_w;
  logic signed [31:0] sat;
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [30:0]        okey_q;
  logic signed [31:0] oqty_q;
  logic [15:0]        ohnd_q;
  logic               olast_q;
  logic               accept;
  logic               out_free;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = cmd_i.in_ready;

  assign sum_w = {rdata_q.qty[31], rdata_q.qty} + {amt_q[31], amt_q};
  always_comb begin
    if (sum_w[32] != sum_w[31]) begin
      sat = sum_w[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat = sum_w[31:0];
    end
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_NEW:  wdata = '{key: key_q, qty: amt_q, hnd: hnd_q};
      WR_SUM:  wdata = '{key: rdata_q.key, qty: sat, hnd: rdata_q.hnd};
      default: wdata = rdata_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_i.func;
      key_q  <= in_i.part_key;
      amt_q  <= in_i.amount;
      hnd_q  <= in_i.name_handle;
    end
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      olast_q  <= cmd_i.out_last;
      case (cmd_i.out_src)
        OUT_NEW: begin
          okey_q <= key_q;
          oqty_q <= amt_q;
          ohnd_q <= hnd_q;
        end
        OUT_SUM: begin
          okey_q <= rdata_q.key;
          oqty_q <= sat;
          ohnd_q <= rdata_q.hnd;
        end
        OUT_MISS: begin
          okey_q <= key_q;
          oqty_q <= '0;
          ohnd_q <= '0;
        end
        OUT_EMPTY: begin
          okey_q <= '0;
          oqty_q <= '0;
          ohnd_q <= '0;
        end
        default: begin
          okey_q <= rdata_q.key;
          oqty_q <= rdata_q.qty;
          ohnd_q <= rdata_q.hnd;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.found_key  = okey_q;
  assign out_o.quantity   = oqty_q;
  assign out_o.handle_out = ohnd_q;
  assign out_o.last       = olast_q;

  assign sts_o.in_valid = in_i.valid;
  assign sts_o.in_func  = in_i.func;
  assign sts_o.func     = func_q;
  assign sts_o.rkey_ge  = (rdata_q.key >= key_q);
  assign sts_o.rkey_eq  = (rdata_q.key == key_q);
  assign sts_o.out_free = out_free;

endmodule

FILE: rtl/skt_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted keyed table controller
// Sequences scan, shift, update and dump over the entry memory.
// ----------------------------------------------------------------------------
`include "sorted_keyed_table_core_assert.svh"

module skt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  skt_pkg::sts_t sts_i,
  output skt_pkg::cmd_t cmd_o
);
  import skt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_QUICK, S_SCAN_RD, S_SCAN_CHK, S_DECIDE,
    S_SHUP_RD, S_SHUP_WR, S_SHDN_RD, S_SHDN_WR, S_DUMP_RD, S_DUMP_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          hit_q, hit_d;
  logic [CW-1:0] idx_m1, idx_p1;

  assign idx_m1 = idx_q - CW'(1);
  assign idx_p1 = idx_q + CW'(1);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    hit_d   = hit_q;
    cmd_o   = '{in_ready: 1'b0, rd_en: 1'b0, rd_addr: idx_q[AW-1:0], wr_en: 1'b0,
                wr_addr: idx_q[AW-1:0], wr_sel: WR_RDATA, out_load: 1'b0,
                out_src: OUT_RDATA, out_status: ST_OK, out_last: 1'b1};
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        idx_d = '0;
        if (sts_i.in_valid) begin
          if (sts_i.in_func == FUNC_DUMP) begin
            state_d = (count_q == '0) ? S_QUICK : S_DUMP_RD;
          end else if (sts_i.in_func == FUNC_INSERT && count_q == CW'(DEPTH)) begin
            state_d = S_QUICK;
          end else if (sts_i.in_func inside {FUNC_SEARCH, FUNC_UPDATE, FUNC_ERASE,
                                             FUNC_INSERT}) begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_QUICK: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.func == FUNC_DUMP) begin
            cmd_o.out_src    = OUT_EMPTY;
            cmd_o.out_status = ST_NOTFOUND;
          end else begin
            cmd_o.out_src    = OUT_MISS;
            cmd_o.out_status = ST_FULL;
          end
          state_d = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (idx_q == count_q) begin
          pos_d   = idx_q;
          hit_d   = 1'b0;
          state_d = S_DECIDE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts_i.rkey_ge) begin
          pos_d   = idx_q;
          hit_d   = sts_i.rkey_eq;
          state_d = S_DECIDE;
        end else begin
          idx_d   = idx_p1;
          state_d = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        if (sts_i.func == FUNC_INSERT && !hit_q) begin
          idx_d   = count_q;
          state_d = S_SHUP_RD;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
          if (!hit_q) begin
            cmd_o.out_src    = OUT_MISS;
            cmd_o.out_status = ST_NOTFOUND;
          end else if (sts_i.func == FUNC_INSERT) begin
            cmd_o.out_status = ST_EXISTS;
          end else if (sts_i.func == FUNC_UPDATE) begin
            cmd_o.out_src = OUT_SUM;
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_addr = pos_q[AW-1:0];
            cmd_o.wr_sel  = WR_SUM;
          end else if (sts_i.func == FUNC_ERASE) begin
            idx_d   = pos_q;
            state_d = S_SHDN_RD;
          end
        end
      end
      S_SHUP_RD: begin
        if (idx_q == pos_q) begin
          if (sts_i.out_free) begin
            cmd_o.wr_en    = 1'b1;
            cmd_o.wr_sel   = WR_NEW;
            cmd_o.out_load = 1'b1;
            cmd_o.out_src  = OUT_NEW;
            count_d        = count_q + CW'(1);
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = idx_m1[AW-1:0];
          state_d       = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        cmd_o.wr_en = 1'b1;
        idx_d       = idx_m1;
        state_d     = S_SHUP_RD;
      end
      S_SHDN_RD: begin
        if (idx_p1 >= count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = idx_p1[AW-1:0];
          state_d       = S_SHDN_WR;
        end
      end
      S_SHDN_WR: begin
        cmd_o.wr_en = 1'b1;
        idx_d       = idx_p1;
        state_d     = S_SHDN_RD;
      end
      S_DUMP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (idx_p1 == count_q);
          idx_d          = idx_p1;
          state_d        = (idx_p1 == count_q) ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      pos_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      hit_q   <= hit_d;
    end
  end

  `SKT_ASSERT(a_count_range, count_q <= CW'(DEPTH), "entry count above depth")
  `SKT_ASSERT(a_rd_wr_excl, !(cmd_o.rd_en && cmd_o.wr_en), "read and write in one cycle")
  `SKT_ASSERT(a_load_free, cmd_o.out_load |-> sts_i.out_free, "result load while busy")
  `SKT_ASSERT(a_count_step, (count_q != $past(count_q)) |-> $past(state_q == S_SHUP_RD ||
              state_q == S_SHDN_RD), "entry count changed outside a shift")

endmodule

FILE: rtl/sorted_keyed_table_core.sv
// ----------------------------------------------------------------------------
// Sorted keyed table core
// Key-sorted table of entries with insert, search, update, erase and dump.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_i     in   func, part_key, amount, name_handle
// out_o    out  status, found_key, quantity, handle_out, last
//
// Lookup scans the memory entry by entry, read then compare, up to the key position (N).
// Insert then shifts entries up, erase shifts them down, each entry read then written.
// Dump reads and emits each entry in turn; full table and empty dump answer without a scan.
// The result register holds a result until transferred; work stalls on it.
// Reset clears the entry count and result valid, not the memory; no clearing pass.
module sorted_keyed_table_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_in_if.sink    in_i,
  skt_out_if.source out_o
);
  import skt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  skt_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
